// ===== hw/rtl/ckw_pkg.sv =====
// Shared types and constants for the canonical k-mer window block.
package ckw_pkg;

   // Fixed field widths
   localparam int CHAR_W   = 8;
   localparam int KSIZE_W  = 5;
   localparam int KMER_W   = 62;
   localparam int SYM_W    = 2;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   // Default window capacity in bases
   localparam int MAX_K_DEFAULT = 31;

   // Register map (word index)
   localparam logic REG_KMER_SIZE = 1'b0;

   // Register reset values
   localparam logic [KSIZE_W-1:0] KMER_SIZE_RESET = 5'd31;

   // Base decoding constants
   localparam logic [CHAR_W-1:0] CASE_FOLD_MASK = 8'd223;
   localparam logic [CHAR_W-1:0] CHAR_C         = 8'h43;
   localparam logic [CHAR_W-1:0] CHAR_T         = 8'h54;
   localparam logic [CHAR_W-1:0] CHAR_G         = 8'h47;
   localparam logic [CHAR_W-1:0] A_TO_C_BIT     = 8'h02;
   localparam logic [SYM_W-1:0]  COMP_MASK      = 2'b10;

   // Contents of one window position
   typedef struct packed {
      logic [SYM_W-1:0] fwd;
      logic [SYM_W-1:0] rev;
      logic             bad;
   } cell_state_type;

   // Broadcast shift control for all cells
   typedef struct packed {
      logic             advance;
      logic             front;
      logic             restart;
      logic [SYM_W-1:0] code;
      logic [SYM_W-1:0] comp;
      logic             bad;
   } shift_ctl_type;

   // Where a cell sits relative to the current window length
   typedef struct packed {
      logic bottom;
      logic top;
      logic in_win;
   } cell_pos_type;

   // Test one byte for A, C, G or T in either case
   function automatic logic base_is_valid(input logic [CHAR_W-1:0] ch);
      logic [CHAR_W-1:0] up;
      up = ch & CASE_FOLD_MASK;
      return ((up | A_TO_C_BIT) == CHAR_C) || (up == CHAR_T) || (up == CHAR_G);
   endfunction

endpackage

// ===== hw/rtl/canonical_kmer_window.sv =====
// Top level of the rolling canonical k-mer window.
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_ready  base_char, func, restart
//   rsp       out        rsp_valid/rsp_ready  canonical/forward/reverse kmer, window_valid
//   csr       in         APB psel/penable     kmer_size at byte address 0
//
// One request per cycle while rsp_ready keeps the result register moving; rsp_valid rises
// once the chain of cells has updated at the accepting edge and the result register has loaded.
// A request is taken while a result waits, as long as the cell chain has moved its
// previous result on. Synchronous reset clears the windows and sets kmer_size to 31.
module canonical_kmer_window #(
   parameter int MAX_K = ckw_pkg::MAX_K_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ckw_pkg::CHAR_W-1:0]    req_base_char,
   input  logic                          req_func,
   input  logic                          req_restart,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ckw_pkg::KMER_W-1:0]    rsp_canonical_kmer,
   output logic [ckw_pkg::KMER_W-1:0]    rsp_forward_kmer,
   output logic [ckw_pkg::KMER_W-1:0]    rsp_reverse_kmer,
   output logic                          rsp_window_valid,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [ckw_pkg::CSR_AW-1:0]    paddr,
   input  logic [ckw_pkg::CSR_DW-1:0]    pwdata,
   output logic [ckw_pkg::CSR_DW-1:0]    prdata,
   output logic                          pready
);

   localparam int KW = ckw_pkg::KSIZE_W;

   logic [KW-1:0]              kmer_size_ff;
   logic [KW-1:0]              k_eff;
   logic                       csr_write;
   logic                       s1_valid_ff;
   logic                       s1_valid_in;
   logic                       s2_ready;
   logic                       accept;
   logic                       base_ok;
   ckw_pkg::shift_ctl_type     ctl;
   ckw_pkg::cell_state_type    cell_q [MAX_K];
   logic [2*MAX_K-1:0]         fwd_cat;
   logic [2*MAX_K-1:0]         rev_cat;
   logic [MAX_K-1:0]           bad_cat;
   logic [ckw_pkg::KMER_W-1:0] fwd_full;
   logic [ckw_pkg::KMER_W-1:0] rev_full;

   // Register port: always ready, one register
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         kmer_size_ff <= ckw_pkg::KMER_SIZE_RESET;
      end else if (csr_write && (paddr[2] == ckw_pkg::REG_KMER_SIZE)) begin
         kmer_size_ff <= pwdata[KW-1:0];
      end
   end

   assign prdata = (paddr[2] == ckw_pkg::REG_KMER_SIZE) ?
                   ckw_pkg::CSR_DW'(kmer_size_ff) : '0;

   // Clamp the window length to 1..MAX_K
   always_comb begin
      if (kmer_size_ff == '0) begin
         k_eff = KW'(1);
      end else if (kmer_size_ff > KW'(MAX_K)) begin
         k_eff = KW'(MAX_K);
      end else begin
         k_eff = kmer_size_ff;
      end
   end

   // Advance the chain when it is empty or its result moves on
   assign req_ready   = !s1_valid_ff || s2_ready;
   assign accept      = req_valid && req_ready;
   assign s1_valid_in = accept || (s1_valid_ff && !s2_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Decode the base and broadcast shift control
   assign base_ok = ckw_pkg::base_is_valid(req_base_char);

   always_comb begin
      ctl.advance = accept;
      ctl.front   = req_func;
      ctl.restart = req_restart;
      ctl.code    = base_ok ? req_base_char[2:1] : '0;
      ctl.comp    = ctl.code ^ ckw_pkg::COMP_MASK;
      ctl.bad     = !base_ok;
   end

   // Chain of window positions, position 0 is the low symbol
   for (genvar i = 0; i < MAX_K; i++) begin : g_cell
      ckw_pkg::cell_state_type lo_nb;
      ckw_pkg::cell_state_type hi_nb;
      ckw_pkg::cell_pos_type   pos;

      if (i == 0) begin : g_lo_end
         assign lo_nb = '0;
      end else begin : g_lo_nb
         assign lo_nb = cell_q[i-1];
      end

      if (i == MAX_K-1) begin : g_hi_end
         assign hi_nb = '0;
      end else begin : g_hi_nb
         assign hi_nb = cell_q[i+1];
      end

      assign pos.bottom = (i == 0);
      assign pos.top    = (KW'(i) == (k_eff - KW'(1)));
      assign pos.in_win = (KW'(i) < k_eff);

      ckw_cell u_cell (
         .clock (clock),
         .reset (reset),
         .ctl   (ctl),
         .pos   (pos),
         .lo_nb (lo_nb),
         .hi_nb (hi_nb),
         .state (cell_q[i])
      );

      assign fwd_cat[2*i +: 2] = cell_q[i].fwd;
      assign rev_cat[2*i +: 2] = cell_q[i].rev;
      assign bad_cat[i]        = cell_q[i].bad;
   end

   assign fwd_full = ckw_pkg::KMER_W'(fwd_cat);
   assign rev_full = ckw_pkg::KMER_W'(rev_cat);

   // Result register
   ckw_out u_out (
      .clock              (clock),
      .reset              (reset),
      .in_valid           (s1_valid_ff),
      .in_ready           (s2_ready),
      .in_fwd             (fwd_full),
      .in_rev             (rev_full),
      .in_window_valid    (bad_cat == '0),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_canonical_kmer (rsp_canonical_kmer),
      .rsp_forward_kmer   (rsp_forward_kmer),
      .rsp_reverse_kmer   (rsp_reverse_kmer),
      .rsp_window_valid   (rsp_window_valid)
   );

endmodule

// ===== hw/rtl/ckw_cell.sv =====
// One window position: forward symbol, reverse-complement symbol and invalid mark.
module ckw_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  ckw_pkg::shift_ctl_type  ctl,
   input  ckw_pkg::cell_pos_type   pos,
   input  ckw_pkg::cell_state_type lo_nb,
   input  ckw_pkg::cell_state_type hi_nb,
   output ckw_pkg::cell_state_type state
);

   ckw_pkg::cell_state_type state_ff;
   ckw_pkg::cell_state_type state_in;
   ckw_pkg::cell_state_type lo_v;
   ckw_pkg::cell_state_type hi_v;

   // Drop neighbor contents on restart
   always_comb begin
      lo_v = ctl.restart ? '0 : lo_nb;
      hi_v = ctl.restart ? '0 : hi_nb;
   end

   // Take from the neighbor on the shift side, inject the new base at the ends
   always_comb begin
      if (ctl.front) begin
         state_in.fwd = hi_v.fwd | (pos.top    ? ctl.code : '0);
         state_in.rev = lo_v.rev | (pos.bottom ? ctl.comp : '0);
         state_in.bad = hi_v.bad | (pos.top    & ctl.bad);
      end else begin
         state_in.fwd = lo_v.fwd | (pos.bottom ? ctl.code : '0);
         state_in.rev = hi_v.rev | (pos.top    ? ctl.comp : '0);
         state_in.bad = lo_v.bad | (pos.bottom & ctl.bad);
      end
      // Clear positions beyond the window
      if (!pos.in_win) begin
         state_in = '0;
      end
   end

   // Hold state until a request is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (ctl.advance) begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;

endmodule

// ===== hw/rtl/ckw_out.sv =====
// Result stage: canonical minimum and output register.
module ckw_out (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [ckw_pkg::KMER_W-1:0]  in_fwd,
   input  logic [ckw_pkg::KMER_W-1:0]  in_rev,
   input  logic                        in_window_valid,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [ckw_pkg::KMER_W-1:0]  rsp_canonical_kmer,
   output logic [ckw_pkg::KMER_W-1:0]  rsp_forward_kmer,
   output logic [ckw_pkg::KMER_W-1:0]  rsp_reverse_kmer,
   output logic                        rsp_window_valid
);

   logic                       valid_ff;
   logic                       valid_in;
   logic [ckw_pkg::KMER_W-1:0] canon_ff;
   logic [ckw_pkg::KMER_W-1:0] canon_in;
   logic [ckw_pkg::KMER_W-1:0] fwd_ff;
   logic [ckw_pkg::KMER_W-1:0] rev_ff;
   logic                       wvalid_ff;
   logic                       load;

   // Accept a new result when empty or when the held one leaves
   assign in_ready = !valid_ff || rsp_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   // Pick the smaller strand
   assign canon_in = (in_fwd < in_rev) ? in_fwd : in_rev;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      if (load) begin
         canon_ff  <= canon_in;
         fwd_ff    <= in_fwd;
         rev_ff    <= in_rev;
         wvalid_ff <= in_window_valid;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_canonical_kmer = canon_ff;
   assign rsp_forward_kmer   = fwd_ff;
   assign rsp_reverse_kmer   = rev_ff;
   assign rsp_window_valid   = wvalid_ff;

endmodule

// ===== bench/tb_canonical_kmer_window.sv =====
// Self-checking testbench for the rolling canonical k-mer window block.
module tb_canonical_kmer_window;
   import ckw_pkg::*;

   localparam int MAX_K = MAX_K_DEFAULT;
   localparam int QUIET_LIMIT = 600;
   localparam logic [CSR_AW-1:0] KSIZE_ADDR = {REG_KMER_SIZE, 2'b00};

   // One expected result
   typedef struct packed {
      logic [KMER_W-1:0] canon;
      logic [KMER_W-1:0] fwd;
      logic [KMER_W-1:0] rev;
      logic              win_ok;
   } kmer_result_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [CHAR_W-1:0]   req_base_char;
   logic                req_func;
   logic                req_restart;
   logic                rsp_valid;
   logic                rsp_ready = 1'b1;
   logic [KMER_W-1:0]   rsp_canonical_kmer;
   logic [KMER_W-1:0]   rsp_forward_kmer;
   logic [KMER_W-1:0]   rsp_reverse_kmer;
   logic                rsp_window_valid;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [CSR_AW-1:0]   paddr;
   logic [CSR_DW-1:0]   pwdata;
   logic [CSR_DW-1:0]   prdata;
   logic                pready;

   // Predictor state
   logic [KSIZE_W-1:0]  kmer_size_q = KMER_SIZE_RESET;
   logic [63:0]         fwd_win = '0;
   logic [63:0]         rev_win = '0;
   logic [63:0]         bad_marks = '0;
   kmer_result_type     pending_kmers[$];

   int unsigned         error_count = 0;
   int unsigned         quiet_cycles = 0;
   int unsigned         ready_hold = 0;
   logic                calm = 1'b0;
   string               nuc_chars = "ACGTacgt";

   canonical_kmer_window #(.MAX_K(MAX_K)) uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_base_char      (req_base_char),
      .req_func           (req_func),
      .req_restart        (req_restart),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_canonical_kmer (rsp_canonical_kmer),
      .rsp_forward_kmer   (rsp_forward_kmer),
      .rsp_reverse_kmer   (rsp_reverse_kmer),
      .rsp_window_valid   (rsp_window_valid),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Shift one base into the predicted windows and return the expected result
   function automatic kmer_result_type shift_base(input logic [CHAR_W-1:0] ch,
                                                  input logic front, input logic clear);
      int unsigned  k;
      int unsigned  left;
      logic [63:0]  sym_mask;
      logic [63:0]  pos_mask;
      logic [CHAR_W-1:0] up;
      logic         ok;
      logic [SYM_W-1:0] code;
      logic [SYM_W-1:0] comp;
      kmer_result_type r;
      k = 32'(kmer_size_q);
      if (k == 0) k = 1;
      if (k > MAX_K) k = MAX_K;
      left = 2 * (k - 1);
      sym_mask = (64'd1 << (2 * k)) - 64'd1;
      pos_mask = (64'd1 << k) - 64'd1;
      up = ch & CASE_FOLD_MASK;
      ok = ((up | A_TO_C_BIT) == CHAR_C) || (up == CHAR_T) || (up == CHAR_G);
      code = ok ? ch[2:1] : '0;
      comp = code ^ COMP_MASK;
      if (clear) begin
         fwd_win = '0;
         rev_win = '0;
         bad_marks = '0;
      end
      if (!front) begin
         fwd_win = (fwd_win << 2) | {62'd0, code};
         rev_win = (rev_win >> 2) | ({62'd0, comp} << left);
         bad_marks = (bad_marks << 1) | {63'd0, !ok};
      end else begin
         fwd_win = (fwd_win >> 2) | ({62'd0, code} << left);
         rev_win = (rev_win << 2) | {62'd0, comp};
         bad_marks = (bad_marks >> 1) | ({63'd0, !ok} << (k - 1));
      end
      fwd_win &= sym_mask;
      rev_win &= sym_mask;
      bad_marks &= pos_mask;
      r.fwd = fwd_win[KMER_W-1:0];
      r.rev = rev_win[KMER_W-1:0];
      r.canon = (fwd_win < rev_win) ? r.fwd : r.rev;
      r.win_ok = (bad_marks == 0);
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         $error("%s expected %h got %h", name, want, got);
         error_count++;
      end
   endfunction

   // Compare each accepted result with the oldest prediction
   always @(posedge clock) begin : check_results
      kmer_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_kmers.size() == 0) begin
            $error("result with no request pending");
            error_count++;
         end else begin
            want = pending_kmers.pop_front();
            check_field("canonical_kmer", 64'(want.canon), 64'(rsp_canonical_kmer));
            check_field("forward_kmer", 64'(want.fwd), 64'(rsp_forward_kmer));
            check_field("reverse_kmer", 64'(want.rev), 64'(rsp_reverse_kmer));
            check_field("window_valid", 64'(want.win_ok), 64'(rsp_window_valid));
         end
      end
   end

   // Stall the result side in random bursts; hold ready high once calm
   always @(posedge clock) begin
      if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else if (calm) begin
         rsp_ready <= 1'b1;
      end else if (rsp_ready) begin
         if ($urandom_range(0, 1) == 0) begin
            rsp_ready <= 1'b0;
            ready_hold <= $urandom_range(0, 12);
         end else begin
            ready_hold <= $urandom_range(0, 40);
         end
      end else begin
         rsp_ready <= 1'b1;
         ready_hold <= $urandom_range(0, 40);
      end
   end

   // End the run when no handshake completes for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("canonical_kmer_window test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one request, wait for it to be taken, then predict its result
   task automatic send_base(input logic [CHAR_W-1:0] ch, input logic front,
                            input logic clear);
      int unsigned gap;
      gap = 0;
      if (!calm && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 13);
      if (gap != 0) begin
         if (req_valid) req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_base_char <= ch;
      req_func <= front;
      req_restart <= clear;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_kmers = {pending_kmers, shift_base(ch, front, clear)};
   endtask

   // Stop requesting and wait until every predicted result has come back
   task automatic drain_results();
      if (req_valid) req_valid <= 1'b0;
      while (pending_kmers.size() != 0) @(posedge clock);
   endtask

   // Write kmer_size with junk in the upper bits, then read it back
   task automatic write_kmer_size(input logic [KSIZE_W-1:0] k);
      logic [CSR_DW-1:0] data;
      drain_results();
      data = ($urandom & ~32'h1F) | {27'd0, k};
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= KSIZE_ADDR;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      kmer_size_q = k;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata[KSIZE_W-1:0] !== k) begin
         $error("kmer_size expected %0d got %0d", k, prdata[KSIZE_W-1:0]);
         error_count++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // Default window length: every base case, invalid bytes and a restart
   task automatic test_reset_state();
      send_base("A", 1'b0, 1'b0);
      send_base("C", 1'b0, 1'b0);
      send_base("G", 1'b0, 1'b0);
      send_base("T", 1'b0, 1'b0);
      send_base("a", 1'b1, 1'b0);
      send_base("c", 1'b1, 1'b0);
      send_base("g", 1'b1, 1'b0);
      send_base("t", 1'b1, 1'b0);
      send_base("N", 1'b0, 1'b0);
      send_base(8'h00, 1'b1, 1'b0);
      send_base(8'hFF, 1'b0, 1'b0);
      send_base("G", 1'b0, 1'b1);
   endtask

   // Zero, even, shrinking and growing window lengths
   task automatic test_window_sizes();
      write_kmer_size(5'd0);
      send_base("T", 1'b0, 1'b0);
      send_base("g", 1'b1, 1'b0);
      write_kmer_size(5'd2);
      send_base("C", 1'b0, 1'b0);
      send_base("A", 1'b1, 1'b0);
      send_base("x", 1'b0, 1'b0);
      write_kmer_size(5'd7);
      send_base("G", 1'b0, 1'b0);
      send_base("t", 1'b0, 1'b0);
      send_base("C", 1'b1, 1'b0);
      send_base("#", 1'b1, 1'b0);
      write_kmer_size(5'd3);
      send_base("a", 1'b0, 1'b0);
      send_base("G", 1'b1, 1'b0);
      write_kmer_size(5'd31);
      send_base("T", 1'b0, 1'b0);
   endtask

   // One setting of kmer_size followed by a random base stream
   task automatic run_phase(input logic [KSIZE_W-1:0] k, input int unsigned count,
                            input int unsigned bad_pct);
      int unsigned       i;
      int unsigned       front_mode;
      logic [CHAR_W-1:0] ch;
      logic              front;
      write_kmer_size(k);
      front_mode = $urandom_range(0, 2);
      for (i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < bad_pct) ch = CHAR_W'($urandom_range(0, 255));
         else ch = nuc_chars[$urandom_range(0, 7)];
         case (front_mode)
            0: front = ($urandom_range(0, 15) == 0);
            1: front = ($urandom_range(0, 15) != 0);
            default: front = 1'($urandom_range(0, 1));
         endcase
         send_base(ch, front, $urandom_range(0, 99) < 2);
         // occasionally hold off until the pipeline is empty
         if ($urandom_range(0, 149) == 0) drain_results();
      end
   endtask

   // Random streams across several window lengths, quiet last phase
   task automatic test_random_stream();
      run_phase(5'd1, 140, 10);
      run_phase(5'd31, 140, 0);
      run_phase(5'd3, 140, 30);
      run_phase(5'd5, 140, 2);
      run_phase(5'd2, 140, 10);
      run_phase(5'd0, 140, 30);
      run_phase(5'd31, 140, 2);
      run_phase(5'd16, 140, 0);
      run_phase(KSIZE_W'($urandom_range(0, 31)), 140, 2);
      run_phase(KSIZE_W'($urandom_range(0, 31)), 140, 30);
      run_phase(KSIZE_W'($urandom_range(0, 31)), 140, 0);
      calm = 1'b1;
      run_phase(KSIZE_W'($urandom_range(1, 31)), 110, 5);
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_base_char <= '0;
      req_func <= 1'b0;
      req_restart <= 1'b0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_window_sizes();
      test_random_stream();
      drain_results();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("canonical_kmer_window test passed");
      end else begin
         $display("canonical_kmer_window test failed");
      end
      $finish;
   end

endmodule
